// ===== sv/set_reduce_min_max_sum_avg_assert.svh =====
// assertion macros for the set reducer checker
// no dependencies; included by the checker file only
`ifndef SET_REDUCE_MIN_MAX_SUM_AVG_ASSERT_SVH
`define SET_REDUCE_MIN_MAX_SUM_AVG_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SRMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("set reducer assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SRMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("set reducer assertion failed");

`endif

// ===== sv/srmm_pkg.sv =====
// shared types, codes and constants of the set reducer
// no dependencies; used by every module of the block
package srmm_pkg;

	localparam int VALUE_W = 64;
	localparam int DIGIT_W = 8;
	localparam int DIGITS  = VALUE_W / DIGIT_W;
	localparam int STEP_W  = $clog2(VALUE_W);

	localparam int DEF_MAX_SET_ITEMS = 65536;
	localparam int DEF_FRACTION_BITS = 32;

	localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] NEG_MAX = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [DIGIT_W-1:0] DIGIT_MSB = {1'b1, {(DIGIT_W-1){1'b0}}};

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MODE    = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REDUCE_SELECT = 4'd1;

	typedef enum logic [2:0] {
		FUNC_MIN   = 3'd0,
		FUNC_AVG   = 3'd1,
		FUNC_MAX   = 3'd2,
		FUNC_SUM   = 3'd3,
		FUNC_COUNT = 3'd4,
		FUNC_LAST  = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_APPLY,
		ST_RESULT,
		ST_NEG,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] sample_value;
		logic               last_in_set;
	} sample_t;

	typedef struct packed {
		logic [VALUE_W-1:0] reduced_value;
		logic               overflow_flag;
	} result_t;

	// digit adder control: b operand inversion and carry into the digit
	typedef struct packed {
		logic invert_b;
		logic carry_in;
	} alu_ctrl_t;

endpackage

// ===== sv/srmm_digit_alu.sv =====
// one-digit adder with optional inversion of the second operand
// depends on srmm_pkg for the digit width and the control struct
module srmm_digit_alu (
	input  logic [srmm_pkg::DIGIT_W-1:0] a,
	input  logic [srmm_pkg::DIGIT_W-1:0] b,
	input  srmm_pkg::alu_ctrl_t          ctrl,
	output logic [srmm_pkg::DIGIT_W-1:0] sum,
	output logic                         carry_out
);

	logic [srmm_pkg::DIGIT_W:0] total;

	assign total = {1'b0, a}
		+ {1'b0, b ^ {srmm_pkg::DIGIT_W{ctrl.invert_b}}}
		+ {{srmm_pkg::DIGIT_W{1'b0}}, ctrl.carry_in};
	assign sum       = total[srmm_pkg::DIGIT_W-1:0];
	assign carry_out = total[srmm_pkg::DIGIT_W];

endmodule

// ===== sv/set_reduce_min_max_sum_avg.sv =====
// set reducer top level: min, average, max, sum, count or first item of each set
// depends on srmm_pkg and srmm_digit_alu
//
// usage
//   sample channel: sample_valid / sample_ready, payload sample (value and
//   last_in_set). result channel: result_valid / result_ready, payload result
//   (reduced value and overflow flag), one item per closed set.
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
//   index 0 value mode, index 1 reduce select, other indexes are ignored.
//   write registers only while the block is idle.
// sequencing
//   the first item of a set and items under count or first are taken in the
//   accept state alone. other items go through the 64-bit value 8 bits a
//   cycle in the shared digit adder: accept, 8 digit steps, apply.
//   a closing item adds result select and hand-off; average adds the
//   restoring divider, one quotient bit a cycle, and for a negative
//   signed sum two digit-serial negations around it.
// reset
//   arst_n clears the registers, the open set and the result valid flag.
// stalls
//   a finished result sits in the output register while the next items are
//   taken; a second result waits in the hand-off state until it is free.
module set_reduce_min_max_sum_avg #(
	parameter int MAX_SET_ITEMS = srmm_pkg::DEF_MAX_SET_ITEMS,
	parameter int FRACTION_BITS = srmm_pkg::DEF_FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  srmm_pkg::sample_t                 sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output srmm_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [srmm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int VW    = srmm_pkg::VALUE_W;
	localparam int DW    = srmm_pkg::DIGIT_W;
	localparam int SW    = srmm_pkg::STEP_W;
	localparam int CNT_W = $clog2(MAX_SET_ITEMS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_SET_ITEMS);
	localparam logic [VW-1:0]    CNT_LIMIT = srmm_pkg::POS_MAX >> FRACTION_BITS;
	localparam logic [SW-1:0]    DIGIT_END = SW'(srmm_pkg::DIGITS - 1);
	localparam logic [SW-1:0]    DIV_END   = SW'(VW - 1);

	// configuration registers
	logic            mode_q;
	srmm_pkg::func_t select_q;

	// control state
	srmm_pkg::state_t state_q, state_d;
	logic             open_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [SW-1:0]    step_q;
	logic             neg_q;
	logic             div_done_q;
	logic             result_valid_q;

	// datapath
	logic [VW-1:0]    acc_q;
	logic [VW-1:0]    x_q;
	logic             last_q;
	logic             carry_q;
	logic             lt_q;
	logic             acc_sign_q;
	logic [CNT_W-1:0] rem_q;
	srmm_pkg::result_t result_q;

	// digit adder hookup
	logic [DW-1:0]       alu_a, alu_b, alu_sum;
	logic                alu_cout;
	srmm_pkg::alu_ctrl_t alu_ctrl;
	logic                carry_init;

	logic accept, fold_cmp, fold_sel, last_step, emit_load, top_digit;
	logic sum_sat, cnt_too_big;
	logic [VW-1:0]  cnt_wide;
	logic [CNT_W:0] rem_shift, rem_diff;
	logic           div_ge;

	assign accept    = sample_valid && sample_ready;
	assign fold_cmp  = (select_q == srmm_pkg::FUNC_MIN) || (select_q == srmm_pkg::FUNC_MAX);
	assign fold_sel  = fold_cmp || (select_q == srmm_pkg::FUNC_AVG)
		|| (select_q == srmm_pkg::FUNC_SUM);
	assign top_digit = (step_q == DIGIT_END);

	// signed overflow of the finished sum: equal operand signs, different result sign
	assign sum_sat = mode_q && (acc_sign_q == x_q[VW-1]) && (acc_sign_q != acc_q[VW-1]);

	// count result in fixed point
	assign cnt_wide    = {{(VW-CNT_W){1'b0}}, count_q};
	assign cnt_too_big = cnt_wide > CNT_LIMIT;

	// restoring divider step, dividend and quotient share acc_q
	assign rem_shift = {rem_q, acc_q[VW-1]};
	assign rem_diff  = rem_shift - {1'b0, count_q};
	assign div_ge    = rem_shift >= {1'b0, count_q};

	srmm_digit_alu u_alu (
		.a         (alu_a),
		.b         (alu_b),
		.ctrl      (alu_ctrl),
		.sum       (alu_sum),
		.carry_out (alu_cout)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srmm_pkg::ST_IDLE: begin
				if (sample_valid) begin
					if (open_q && fold_sel) state_d = srmm_pkg::ST_FOLD;
					else if (sample.last_in_set) state_d = srmm_pkg::ST_RESULT;
				end
			end
			srmm_pkg::ST_FOLD: begin
				if (top_digit) state_d = srmm_pkg::ST_APPLY;
			end
			srmm_pkg::ST_APPLY: begin
				state_d = last_q ? srmm_pkg::ST_RESULT : srmm_pkg::ST_IDLE;
			end
			srmm_pkg::ST_RESULT: begin
				if (select_q == srmm_pkg::FUNC_AVG)
					state_d = (mode_q && acc_q[VW-1]) ? srmm_pkg::ST_NEG : srmm_pkg::ST_DIV;
				else
					state_d = srmm_pkg::ST_EMIT;
			end
			srmm_pkg::ST_NEG: begin
				if (top_digit) state_d = div_done_q ? srmm_pkg::ST_EMIT : srmm_pkg::ST_DIV;
			end
			srmm_pkg::ST_DIV: begin
				if (step_q == DIV_END) state_d = neg_q ? srmm_pkg::ST_NEG : srmm_pkg::ST_EMIT;
			end
			srmm_pkg::ST_EMIT: begin
				if (!result_valid_q || result_ready) state_d = srmm_pkg::ST_IDLE;
			end
			default: state_d = srmm_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		sample_ready = 1'b0;
		emit_load    = 1'b0;
		last_step    = 1'b0;
		alu_a        = acc_q[DW-1:0];
		alu_b        = x_q[DW-1:0];
		carry_init   = 1'b0;
		alu_ctrl.invert_b = 1'b0;
		unique case (state_q)
			srmm_pkg::ST_IDLE: sample_ready = 1'b1;
			srmm_pkg::ST_FOLD: begin
				last_step = top_digit;
				if (fold_cmp) begin
					// min: x - acc, max: acc - x; borrow means less than
					if (select_q == srmm_pkg::FUNC_MIN) begin
						alu_a = x_q[DW-1:0];
						alu_b = acc_q[DW-1:0];
					end
					if (mode_q && top_digit) begin
						alu_a = alu_a ^ srmm_pkg::DIGIT_MSB;
						alu_b = alu_b ^ srmm_pkg::DIGIT_MSB;
					end
					alu_ctrl.invert_b = 1'b1;
					carry_init        = 1'b1;
				end
			end
			srmm_pkg::ST_NEG: begin
				// two's complement: 0 - acc
				last_step         = top_digit;
				alu_a             = '0;
				alu_b             = acc_q[DW-1:0];
				alu_ctrl.invert_b = 1'b1;
				carry_init        = 1'b1;
			end
			srmm_pkg::ST_DIV: last_step = (step_q == DIV_END);
			srmm_pkg::ST_EMIT: emit_load = !result_valid_q || result_ready;
			default: ;
		endcase
		alu_ctrl.carry_in = (step_q == '0) ? carry_init : carry_q;
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			select_q       <= srmm_pkg::FUNC_MIN;
			state_q        <= srmm_pkg::ST_IDLE;
			open_q         <= 1'b0;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			step_q         <= '0;
			neg_q          <= 1'b0;
			div_done_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == srmm_pkg::REG_VALUE_MODE) mode_q <= cfg_data[0];
				if (cfg_index == srmm_pkg::REG_REDUCE_SELECT)
					select_q <= srmm_pkg::func_t'(cfg_data[2:0]);
			end

			if (state_q == srmm_pkg::ST_FOLD || state_q == srmm_pkg::ST_NEG
					|| state_q == srmm_pkg::ST_DIV)
				step_q <= last_step ? '0 : step_q + SW'(1);

			if (accept) begin
				step_q <= '0;
				if (!open_q) begin
					// first item of a set
					open_q  <= 1'b1;
					count_q <= CNT_W'(1);
					ovf_q   <= 1'b0;
				end else if (count_q >= CNT_MAX) begin
					count_q <= CNT_MAX;
					ovf_q   <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end

			if (state_q == srmm_pkg::ST_APPLY && !fold_cmp && sum_sat) ovf_q <= 1'b1;

			if (state_q == srmm_pkg::ST_RESULT) begin
				neg_q      <= mode_q && acc_q[VW-1];
				div_done_q <= 1'b0;
				step_q     <= '0;
				if (select_q == srmm_pkg::FUNC_COUNT && mode_q && cnt_too_big) ovf_q <= 1'b1;
			end

			if (state_q == srmm_pkg::ST_DIV && last_step) div_done_q <= 1'b1;

			// result register and return to an empty set
			if (emit_load) begin
				result_valid_q <= 1'b1;
				open_q         <= 1'b0;
				count_q        <= '0;
				ovf_q          <= 1'b0;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample.sample_value;
			last_q <= sample.last_in_set;
			if (!open_q) acc_q <= sample.sample_value;
		end

		unique case (state_q)
			srmm_pkg::ST_FOLD: begin
				// both words rotate one digit; a sum replaces the acc digit
				carry_q <= alu_cout;
				x_q     <= {x_q[DW-1:0], x_q[VW-1:DW]};
				if (fold_cmp) acc_q <= {acc_q[DW-1:0], acc_q[VW-1:DW]};
				else acc_q <= {alu_sum, acc_q[VW-1:DW]};
				if (top_digit) begin
					lt_q       <= !alu_cout;
					acc_sign_q <= acc_q[DW-1];
				end
			end
			srmm_pkg::ST_APPLY: begin
				if (fold_cmp) begin
					if (lt_q) acc_q <= x_q;
				end else if (sum_sat) begin
					acc_q <= acc_sign_q ? srmm_pkg::NEG_MAX : srmm_pkg::POS_MAX;
				end
			end
			srmm_pkg::ST_RESULT: begin
				rem_q <= '0;
				unique case (select_q)
					srmm_pkg::FUNC_MIN, srmm_pkg::FUNC_MAX, srmm_pkg::FUNC_SUM,
					srmm_pkg::FUNC_LAST, srmm_pkg::FUNC_AVG: ;
					srmm_pkg::FUNC_COUNT: begin
						if (!mode_q) acc_q <= cnt_wide;
						else if (cnt_too_big) acc_q <= srmm_pkg::POS_MAX;
						else acc_q <= cnt_wide << FRACTION_BITS;
					end
					default: acc_q <= '0;
				endcase
			end
			srmm_pkg::ST_NEG: begin
				carry_q <= alu_cout;
				acc_q   <= {alu_sum, acc_q[VW-1:DW]};
			end
			srmm_pkg::ST_DIV: begin
				rem_q <= div_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
				acc_q <= {acc_q[VW-2:0], div_ge};
			end
			default: ;
		endcase

		if (emit_load) begin
			result_q.reduced_value <= acc_q;
			result_q.overflow_flag <= ovf_q;
		end
	end

endmodule

// ===== sv/set_reduce_min_max_sum_avg_checker.sv =====
// port-level checks of the set reducer, bound to the top level
// depends on srmm_pkg and set_reduce_min_max_sum_avg_assert.svh
`include "set_reduce_min_max_sum_avg_assert.svh"

module set_reduce_min_max_sum_avg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input srmm_pkg::sample_t sample,
	input logic              result_valid,
	input logic              result_ready,
	input srmm_pkg::result_t result,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	// a stalled result item holds
	`SRMM_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// register writes never stall
	`SRMM_ASSERT_IMP(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

	// a closing item keeps the sample side busy while its result forms
	`SRMM_ASSERT_NXT(a_busy_after_last, clk, arst_n, sample_valid && sample_ready && sample.last_in_set, !sample_ready)

	// a new result only comes out of a busy cycle
	`SRMM_ASSERT_IMP(a_result_from_busy, clk, arst_n, $rose(result_valid), !$past(sample_ready))

endmodule

bind set_reduce_min_max_sum_avg set_reduce_min_max_sum_avg_checker u_checker (.*);

// ===== bench/tb_top.sv =====
// self-checking bench for the set reducer: min, average, max, sum, count and first item per set
// depends on srmm_pkg and the set_reduce_min_max_sum_avg top level, nothing else
`timescale 1ns / 1ps

module tb_top;

	// bench sizing, taken from the block defaults
	localparam int MAX_ITEMS      = srmm_pkg::DEF_MAX_SET_ITEMS;
	localparam int FRACTION       = srmm_pkg::DEF_FRACTION_BITS;
	// longest internal work: digit-serial fold, close, 64-step divide and two negations
	localparam int QUIET_CYCLES   = 120;
	localparam int TAIL_CYCLES    = 150;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	// selector codes with no function behind them
	localparam logic [2:0] SEL_SPARE_LO = 3'd6;
	localparam logic [2:0] SEL_SPARE_HI = 3'd7;

	// tracks the open set as the block should see it and holds one expected
	// result per closed set, oldest first
	class set_reduction_scoreboard;
		logic        value_mode_q = 1'b0;
		logic [2:0]  select_q     = srmm_pkg::FUNC_MIN;
		logic [63:0] running      = '0;
		int unsigned members      = 0;
		bit          set_active   = 1'b0;
		bit          sat_seen     = 1'b0;
		srmm_pkg::result_t expected_reductions[$];
		int          mismatches   = 0;
		int          samples_seen = 0;
		int          results_seen = 0;

		function void apply_register(logic [srmm_pkg::CFG_INDEX_W-1:0] index,
				logic [srmm_pkg::CFG_DATA_W-1:0] data);
			if (index == srmm_pkg::REG_VALUE_MODE) begin
				value_mode_q = data[0];
			end else if (index == srmm_pkg::REG_REDUCE_SELECT) begin
				select_q = data[2:0];
			end
		endfunction

		function bit is_less(logic [63:0] a, logic [63:0] b);
			if (value_mode_q)
				return $signed(a) < $signed(b);
			return a < b;
		endfunction

		// wraps in unsigned mode, clamps to the signed extremes in fixed point
		function logic [63:0] add_sample(logic [63:0] a, logic [63:0] b);
			logic [63:0] total;
			total = a + b;
			if (value_mode_q && a[63] == b[63] && total[63] != a[63]) begin
				sat_seen = 1'b1;
				return a[63] ? srmm_pkg::NEG_MAX : srmm_pkg::POS_MAX;
			end
			return total;
		endfunction

		function void note_sample(srmm_pkg::sample_t s);
			logic [63:0] x;
			logic [63:0] outcome;
			logic [63:0] mag;
			logic        flag;
			x = s.sample_value;
			samples_seen++;
			if (!set_active) begin
				running    = x;
				members    = 1;
				set_active = 1'b1;
				sat_seen   = 1'b0;
			end else begin
				if (members >= MAX_ITEMS) begin
					members  = MAX_ITEMS;
					sat_seen = 1'b1;
				end else begin
					members++;
				end
				case (select_q)
					srmm_pkg::FUNC_MIN: if (is_less(x, running)) running = x;
					srmm_pkg::FUNC_MAX: if (is_less(running, x)) running = x;
					srmm_pkg::FUNC_AVG, srmm_pkg::FUNC_SUM: running = add_sample(running, x);
					default: ;
				endcase
			end
			if (!s.last_in_set)
				return;

			// set closes: form the result with the registers in force now
			flag = sat_seen;
			case (select_q)
				srmm_pkg::FUNC_MIN, srmm_pkg::FUNC_MAX, srmm_pkg::FUNC_SUM,
				srmm_pkg::FUNC_LAST: outcome = running;
				srmm_pkg::FUNC_AVG: begin
					if (value_mode_q) begin
						// truncate toward zero on the magnitude
						mag = running[63] ? -running : running;
						mag = mag / 64'(members);
						outcome = running[63] ? -mag : mag;
					end else begin
						outcome = running / 64'(members);
					end
				end
				srmm_pkg::FUNC_COUNT: begin
					if (!value_mode_q) begin
						outcome = 64'(members);
					end else if (64'(members) > (srmm_pkg::POS_MAX >> FRACTION)) begin
						outcome = srmm_pkg::POS_MAX;
						flag    = 1'b1;
					end else begin
						outcome = 64'(members) << FRACTION;
					end
				end
				default: outcome = '0;
			endcase
			expected_reductions.push_back('{reduced_value: outcome, overflow_flag: flag});
			running    = '0;
			members    = 0;
			set_active = 1'b0;
			sat_seen   = 1'b0;
		endfunction

		function void check_result(srmm_pkg::result_t r);
			srmm_pkg::result_t want;
			results_seen++;
			if (expected_reductions.size() == 0) begin
				mismatches++;
				$display("%0t: result with no closed set: expected none, actual value %h flag %b",
					$time, r.reduced_value, r.overflow_flag);
				return;
			end
			want = expected_reductions.pop_front();
			if (r.reduced_value !== want.reduced_value) begin
				mismatches++;
				$display("%0t: reduced_value mismatch: expected %h, actual %h",
					$time, want.reduced_value, r.reduced_value);
			end
			if (r.overflow_flag !== want.overflow_flag) begin
				mismatches++;
				$display("%0t: overflow_flag mismatch: expected %b, actual %b",
					$time, want.overflow_flag, r.overflow_flag);
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             sample_valid;
	logic                             sample_ready;
	srmm_pkg::sample_t                sample;
	logic                             result_valid;
	logic                             result_ready;
	srmm_pkg::result_t                result;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [srmm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [srmm_pkg::CFG_DATA_W-1:0]  cfg_data;

	set_reduction_scoreboard board;

	// idling switches, flipped per phase by the stimulus
	bit tx_idle_on   = 1'b0;
	bit rx_idle_on   = 1'b0;
	// one-shot request for the long result-port stall
	bit hold_request = 1'b0;
	int stall_cycles = 0;

	set_reduce_min_max_sum_avg dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// every handshake is seen here at the rising edge, before the block's
	// own registers move, so the scoreboard follows the block in order
	always @(posedge clk) begin : port_monitor
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				board.apply_register(cfg_index, cfg_data);
				moved = 1'b1;
			end
			if (sample_valid && sample_ready) begin
				board.note_sample(sample);
				moved = 1'b1;
			end
			if (result_valid && result_ready) begin
				board.check_result(result);
				moved = 1'b1;
			end
			// watchdog: a hung block shows up as a long run with no item moving
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, stall_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// result side: ready by default, short random stalls when enabled, and
	// one long stall on request, counted here so the sender keeps pushing
	initial begin : result_sink
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				result_ready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// drop valid for a while; called at a falling edge
	task automatic pause_sender(input int cycles);
		sample_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// offer one item at a falling edge and hold it until taken; returns at
	// the next falling edge, where the caller either offers again or idles
	task automatic offer_sample(input logic [63:0] value, input logic last);
		sample_valid <= 1'b1;
		sample       <= '{sample_value: value, last_in_set: last};
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 4) == 0)
			pause_sender($urandom_range(1, 9));
	endtask

	// sender stops until every closed set has reported, then lets the
	// block finish any fold still in flight before registers change
	task automatic settle_block();
		sample_valid <= 1'b0;
		while (board.expected_reductions.size() != 0) @(posedge clk);
		@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic drive_register(input logic [srmm_pkg::CFG_INDEX_W-1:0] index,
			input logic [srmm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// both registers, with junk in the unused data bits, and now and then a
	// write to an index the block should ignore
	task automatic configure(input logic mode, input logic [2:0] sel);
		logic [srmm_pkg::CFG_DATA_W-1:0] word;
		settle_block();
		word    = srmm_pkg::CFG_DATA_W'($urandom);
		word[0] = mode;
		drive_register(srmm_pkg::REG_VALUE_MODE, word);
		word      = srmm_pkg::CFG_DATA_W'($urandom);
		word[2:0] = sel;
		drive_register(srmm_pkg::REG_REDUCE_SELECT, word);
		if ($urandom_range(0, 3) == 0)
			drive_register(srmm_pkg::CFG_INDEX_W'($urandom_range(
				int'(srmm_pkg::REG_REDUCE_SELECT) + 1, (1 << srmm_pkg::CFG_INDEX_W) - 1)),
				srmm_pkg::CFG_DATA_W'($urandom));
	endtask

	// extremes and values near them, else fully random bits
	function automatic logic [63:0] pick_value();
		logic [63:0] near;
		near = 64'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return srmm_pkg::POS_MAX;
			3: return srmm_pkg::NEG_MAX;
			4: return near;
			5: return -near;
			6: return srmm_pkg::POS_MAX - near;
			7: return srmm_pkg::NEG_MAX + near;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one set of up to three items under a fresh setting
	task automatic directed_set(input logic mode, input logic [2:0] sel,
			input logic [63:0] v0, input logic [63:0] v1, input logic [63:0] v2,
			input int count);
		logic [63:0] vals[3];
		configure(mode, sel);
		vals = '{v0, v1, v2};
		for (int k = 0; k < count; k++)
			offer_sample(vals[k], k == count - 1);
	endtask

	// random settings, each followed by a handful of mostly short sets
	task automatic random_sets(input int item_goal, input bit idling);
		int          sent;
		int          len;
		logic        mode;
		logic [2:0]  sel;
		sent = 0;
		while (sent < item_goal) begin
			mode = 1'($urandom_range(0, 1));
			sel  = ($urandom_range(0, 9) == 0)
				? ($urandom_range(0, 1) ? SEL_SPARE_HI : SEL_SPARE_LO)
				: 3'($urandom_range(int'(srmm_pkg::FUNC_MIN), int'(srmm_pkg::FUNC_LAST)));
			configure(mode, sel);
			// some phases run with no idling at all
			tx_idle_on = idling && $urandom_range(0, 2) != 0;
			rx_idle_on = idling && $urandom_range(0, 2) != 0;
			repeat ($urandom_range(1, 8)) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 4);
				for (int k = 1; k <= len; k++)
					offer_sample(pick_value(), k == len);
				sent += len;
			end
		end
	endtask

	initial begin : stimulus
		board        = new();
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, every function in unsigned mode and all but FUNC_LAST in signed mode
		directed_set(1'b0, srmm_pkg::FUNC_MIN, 64'd5, '0, '1, 3);
		directed_set(1'b0, srmm_pkg::FUNC_MAX, '0, '1, '0, 2);
		// unsigned sum wraps past all ones
		directed_set(1'b0, srmm_pkg::FUNC_SUM, '1, 64'd2, '0, 2);
		directed_set(1'b0, srmm_pkg::FUNC_AVG, '1, '1, 64'd7, 3);
		// single-item set closes at once
		directed_set(1'b0, srmm_pkg::FUNC_COUNT, 64'd7, '0, '0, 1);
		directed_set(1'b0, srmm_pkg::FUNC_LAST, 64'h0123_4567_89ab_cdef, '1, '0, 2);
		directed_set(1'b1, srmm_pkg::FUNC_MIN, 64'd1, srmm_pkg::NEG_MAX, srmm_pkg::POS_MAX, 3);
		directed_set(1'b1, srmm_pkg::FUNC_MAX, 64'hFFFF_FFFF_FFFF_FFFB,
			64'hFFFF_FFFF_FFFF_FFFE, '0, 2);
		// positive saturation, then a later item adds to the clamped sum
		directed_set(1'b1, srmm_pkg::FUNC_SUM, srmm_pkg::POS_MAX, 64'd1, srmm_pkg::NEG_MAX, 3);
		// negative saturation and a negative average truncated toward zero
		directed_set(1'b1, srmm_pkg::FUNC_AVG, srmm_pkg::NEG_MAX, '1,
			64'hFFFF_FFFF_FFFF_FFF9, 3);
		directed_set(1'b1, srmm_pkg::FUNC_COUNT, '1, '0, '0, 2);
		// spare selector codes give zero
		directed_set(1'b0, SEL_SPARE_LO, 64'd3, 64'd4, '0, 2);
		directed_set(1'b1, SEL_SPARE_HI, srmm_pkg::POS_MAX, '0, '0, 1);

		// long result stall while single-item sets keep coming: the output
		// register and hand-off fill and the sample port must back up
		configure(1'b0, srmm_pkg::FUNC_COUNT);
		hold_request = 1'b1;
		repeat (12) offer_sample(pick_value(), 1'b1);

		random_sets(490, 1'b1);

		// closing stretch with no idling on either side
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		random_sets(100, 1'b0);

		sample_valid <= 1'b0;
		while (board.expected_reductions.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d samples and %0d set results in both modes and all select codes,",
			board.samples_seen, board.results_seen);
		$display("with saturated sums, sets of up to 24 items, a backed-up result port and idling");
		if (board.mismatches == 0 && board.expected_reductions.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/srmm_pkg.sv
sv/srmm_digit_alu.sv
sv/set_reduce_min_max_sum_avg.sv
sv/set_reduce_min_max_sum_avg_checker.sv
bench/tb_top.sv
